@@ design/ohlc_bar_aggregator_assert.svh @@
// assertion macros for the ohlc bar aggregator
`ifndef OHLC_BAR_AGGREGATOR_ASSERT_SVH
`define OHLC_BAR_AGGREGATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OHLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OHLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ohlc_pkg.sv @@
// shared constants and controller/datapath types for the ohlc bar aggregator
package ohlc_pkg;

  localparam int TIME_BITS  = 32;
  localparam int TOTAL_BITS = 48;
  localparam int PRICE_BITS = 32;
  localparam int LEN_BITS   = 17;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 3;

  localparam int REG_SEL_BIT = 2;
  localparam logic REG_BAR_SECONDS = 1'b0;
  localparam logic REG_START_TIME  = 1'b1;

  localparam logic [LEN_BITS-1:0]  BAR_SECONDS_RESET = LEN_BITS'(300);
  localparam logic [TIME_BITS-1:0] START_TIME_RESET  = '0;

  localparam int DIV_CNT_BITS = $clog2(TIME_BITS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(TIME_BITS - 1);

  typedef struct packed {
    logic load;
    logic div_start;
    logic mul;
    logic update;
    logic emit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic early;
    logic div_done;
    logic new_bar;
    logic bar_valid;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ design/ohlc_tick_if.sv @@
// tick request channel: valid/ready with one trade tick or flush
interface ohlc_tick_if import ohlc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [TIME_BITS-1:0]  tick_time;
  logic [PRICE_BITS-1:0] price;
  logic [TOTAL_BITS-1:0] cum_volume;
  logic [TOTAL_BITS-1:0] cum_amount;

  modport source (output valid, opcode, tick_time, price, cum_volume, cum_amount,
                  input ready);
  modport sink (input valid, opcode, tick_time, price, cum_volume, cum_amount,
                output ready);
endinterface

@@ design/ohlc_bar_if.sv @@
// bar request channel: valid/ready with one finished ohlc bar
interface ohlc_bar_if import ohlc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TIME_BITS-1:0]  bar_end_time;
  logic [PRICE_BITS-1:0] open_price;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] close_price;
  logic [TOTAL_BITS-1:0] bar_volume;
  logic [TOTAL_BITS-1:0] bar_amount;

  modport source (output valid, bar_end_time, open_price, high_price, low_price,
                  close_price, bar_volume, bar_amount, input ready);
  modport sink (input valid, bar_end_time, open_price, high_price, low_price,
                close_price, bar_volume, bar_amount, output ready);
endinterface

@@ design/ohlc_div.sv @@
// two-lane restoring divider sharing one divisor, one quotient bit per cycle
module ohlc_div import ohlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LEN_BITS-1:0]  divisor,
  input  logic [TIME_BITS-1:0] dividend_a,
  input  logic [TIME_BITS-1:0] dividend_b,
  output logic                 done,
  output logic [TIME_BITS-1:0] quot_a,
  output logic [TIME_BITS-1:0] quot_b
);

  logic [LEN_BITS-1:0]     rem_a, rem_b;
  logic [TIME_BITS-1:0]    sh_a, sh_b;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    run;
  logic [LEN_BITS+TIME_BITS-1:0] step_a, step_b;

  // shift one dividend bit into the remainder, subtract when it fits
  function automatic logic [LEN_BITS+TIME_BITS-1:0] div_step(
    input logic [LEN_BITS-1:0]  rem,
    input logic [TIME_BITS-1:0] sh,
    input logic [LEN_BITS-1:0]  d
  );
    logic [LEN_BITS:0] trial;
    logic [LEN_BITS:0] diff;
    trial = {rem, sh[TIME_BITS-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[LEN_BITS-1:0], sh[TIME_BITS-2:0], 1'b1};
    end else begin
      div_step = {trial[LEN_BITS-1:0], sh[TIME_BITS-2:0], 1'b0};
    end
  endfunction

  assign step_a = div_step(rem_a, sh_a, divisor);
  assign step_b = div_step(rem_b, sh_b, divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_LAST) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_a <= '0;
      rem_b <= '0;
      sh_a  <= dividend_a;
      sh_b  <= dividend_b;
    end else if (run) begin
      {rem_a, sh_a} <= step_a;
      {rem_b, sh_b} <= step_b;
    end
  end

  assign done   = run && (cnt == DIV_LAST);
  assign quot_a = sh_a;
  assign quot_b = sh_b;

endmodule

@@ design/ohlc_dp.sv @@
// datapath: latched tick, bar state, interval divider, start multiply, output register
module ohlc_dp import ohlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic [LEN_BITS-1:0]   bar_seconds,
  input  logic [TIME_BITS-1:0]  start_time,
  input  logic                  opcode,
  input  logic [TIME_BITS-1:0]  tick_time,
  input  logic [PRICE_BITS-1:0] price,
  input  logic [TOTAL_BITS-1:0] cum_volume,
  input  logic [TOTAL_BITS-1:0] cum_amount,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TIME_BITS-1:0]  bar_end_time,
  output logic [PRICE_BITS-1:0] open_price,
  output logic [PRICE_BITS-1:0] high_price,
  output logic [PRICE_BITS-1:0] low_price,
  output logic [PRICE_BITS-1:0] close_price,
  output logic [TOTAL_BITS-1:0] bar_volume,
  output logic [TOTAL_BITS-1:0] bar_amount
);

  localparam int PROD_BITS = TIME_BITS + LEN_BITS;

  logic                  op_r;
  logic [TIME_BITS-1:0]  t_r;
  logic [PRICE_BITS-1:0] p_r;
  logic [TOTAL_BITS-1:0] vol_r, amt_r;

  logic                  bar_valid;
  logic [TIME_BITS-1:0]  bar_end;
  logic [PRICE_BITS-1:0] bar_open, bar_high, bar_low, bar_close;
  logic [TOTAL_BITS-1:0] base_volume, base_amount, last_volume, last_amount;

  logic [LEN_BITS-1:0]   len;
  logic [TIME_BITS-1:0]  q_tick, q_end;
  logic                  div_done;
  logic [PROD_BITS-1:0]  prod;
  logic [TIME_BITS-1:0]  start_r;
  logic [TIME_BITS:0]    end_sum;
  logic [TIME_BITS-1:0]  end_next;
  logic                  new_bar;
  logic                  open_bar;

  // zero length behaves as one second
  assign len = (bar_seconds == '0) ? LEN_BITS'(1) : bar_seconds;

  ohlc_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .divisor    (len),
    .dividend_a (t_r),
    .dividend_b (bar_end),
    .done       (div_done),
    .quot_a     (q_tick),
    .quot_b     (q_end)
  );

  assign prod     = PROD_BITS'(q_tick) * PROD_BITS'(len);
  assign end_sum  = {1'b0, start_r} + (TIME_BITS+1)'(len) - (TIME_BITS+1)'(1);
  assign end_next = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];
  assign new_bar  = bar_valid && (q_tick > q_end);
  assign open_bar = !bar_valid || new_bar;

  assign stat.is_flush  = op_r;
  assign stat.early     = (t_r <= start_time);
  assign stat.div_done  = div_done;
  assign stat.new_bar   = new_bar;
  assign stat.bar_valid = bar_valid;
  assign stat.out_busy  = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      t_r   <= tick_time;
      p_r   <= price;
      vol_r <= cum_volume;
      amt_r <= cum_amount;
    end
    if (cmd.mul) begin
      start_r <= prod[TIME_BITS-1:0];
    end
  end

  // bar state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      bar_valid   <= 1'b0;
      base_volume <= '0;
      base_amount <= '0;
    end else if (cmd.update) begin
      bar_valid <= 1'b1;
      if (new_bar) begin
        base_volume <= last_volume;
        base_amount <= last_amount;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      last_volume <= vol_r;
      last_amount <= amt_r;
      bar_close   <= p_r;
      if (open_bar) begin
        bar_end  <= end_next;
        bar_open <= p_r;
        bar_high <= p_r;
        bar_low  <= p_r;
      end else begin
        if (p_r > bar_high) begin
          bar_high <= p_r;
        end
        if (p_r < bar_low) begin
          bar_low <= p_r;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bar_end_time <= bar_end;
      open_price   <= bar_open;
      high_price   <= bar_high;
      low_price    <= bar_low;
      close_price  <= bar_close;
      bar_volume   <= (last_volume >= base_volume) ? (last_volume - base_volume) : '0;
      bar_amount   <= (last_amount >= base_amount) ? (last_amount - base_amount) : '0;
    end
  end

endmodule

@@ design/ohlc_ctrl.sv @@
// controller state machine sequencing one tick or flush at a time
module ohlc_ctrl import ohlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output ctrl_cmd_t cmd,
  input  dp_stat_t  stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.is_flush) begin
          state_next = S_FLUSH;
        end else if (stat.early) begin
          state_next = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (!(stat.new_bar && stat.out_busy)) begin
          cmd.update = 1'b1;
          cmd.emit   = stat.new_bar;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!(stat.bar_valid && stat.out_busy)) begin
          cmd.emit   = stat.bar_valid;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/ohlc_bar_aggregator.sv @@
// top level: ohlc bar aggregator with apb configuration registers
// a tick past the start time goes from accept to state update through eval, the divider
//   steps, multiply and update; a bar it closes shows at the same edge as that update
// a new tick or flush is taken only back in idle, paced by the bit-serial interval divider;
//   an early tick or a flush skips the divider; a flush takes longer while a bar waits at the output
// reset: bar length 300 s, start time 0, no open bar; no clearing pass
`include "ohlc_bar_aggregator_assert.svh"

module ohlc_bar_aggregator import ohlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ohlc_tick_if.sink            tick_in,
  ohlc_bar_if.source           bar_out,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  // configuration registers
  logic [LEN_BITS-1:0]  bar_seconds;
  logic [TIME_BITS-1:0] start_time;
  logic                 cfg_write;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // register select is the word index of the byte address
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_seconds <= BAR_SECONDS_RESET;
      start_time  <= START_TIME_RESET;
    end else if (cfg_write) begin
      case (paddr[REG_SEL_BIT])
        REG_BAR_SECONDS: bar_seconds <= pwdata[LEN_BITS-1:0];
        REG_START_TIME:  start_time  <= pwdata[TIME_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_BAR_SECONDS: prdata = DATA_BITS'(bar_seconds);
      REG_START_TIME:  prdata = DATA_BITS'(start_time);
      default:         prdata = '0;
    endcase
  end

  // controller: accepts a request only when idle, sequences the datapath
  ohlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_in.valid),
    .in_ready (tick_in.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: divider for both interval indexes, bar state, output register
  ohlc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .bar_seconds  (bar_seconds),
    .start_time   (start_time),
    .opcode       (tick_in.opcode),
    .tick_time    (tick_in.tick_time),
    .price        (tick_in.price),
    .cum_volume   (tick_in.cum_volume),
    .cum_amount   (tick_in.cum_amount),
    .out_valid    (bar_out.valid),
    .out_ready    (bar_out.ready),
    .bar_end_time (bar_out.bar_end_time),
    .open_price   (bar_out.open_price),
    .high_price   (bar_out.high_price),
    .low_price    (bar_out.low_price),
    .close_price  (bar_out.close_price),
    .bar_volume   (bar_out.bar_volume),
    .bar_amount   (bar_out.bar_amount)
  );

  // a finished bar never overwrites one still waiting in the output register
  `OHLC_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, !bar_out.valid, "bar overwritten")
  // one request at a time: after accepting, the block is busy next cycle
  `OHLC_ASSERT_NEXT(a_one_at_a_time, clk, rst, tick_in.valid && tick_in.ready,
    !tick_in.ready, "request accepted while busy")
  // a flush leaves no open bar
  `OHLC_ASSERT_NEXT(a_flush_clears, clk, rst, cmd.clear, !stat.bar_valid,
    "bar still open after flush")

endmodule
